### rtl/ftm_pkg.sv
// shared types, sizes and codes for the feature track merge table
package ftm_pkg;

    localparam int NUM_VIEWS   = 8;
    localparam int NUM_CORNERS = 4096;
    localparam int MAX_TRACKS  = 4096;

    localparam int VIEW_W    = $clog2(NUM_VIEWS);
    localparam int CNT_W     = VIEW_W + 1;
    localparam int CORNER_W  = 12;
    localparam int CORNER_AW = $clog2(NUM_CORNERS);
    localparam int SLOT_W    = $clog2(MAX_TRACKS);
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int SEL_W     = 12;
    localparam int VCOUNT_W  = 4;
    localparam int EFF_W     = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_AW    = 2;
    localparam int MAP_AW    = VIEW_W + CORNER_AW;
    localparam int MAP_DEPTH = 2 ** MAP_AW;
    localparam int TS_AW     = SLOT_W + VIEW_W;
    localparam int TS_DEPTH  = 2 ** TS_AW;

    typedef enum logic [CFG_AW-1:0] {
        CFG_VIEW_FIRST = 2'd0,
        CFG_VIEW_STEP  = 2'd1,
        CFG_VIEW_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_MERGED   = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_BAD_VIEW = 3'd3,
        ST_FULL     = 3'd4,
        ST_READ     = 3'd5
    } t_status;

    typedef struct packed {
        logic                mode;
        logic signed [15:0]  view;
        logic [CORNER_W-1:0] corner;
        logic                last_pair;
        logic [SEL_W-1:0]    track_select;
    } t_in;

    typedef struct packed {
        logic [2:0]          status;
        logic [SEL_W-1:0]    track_id;
        logic [COUNT_W-1:0]  track_total;
        logic [CORNER_W-1:0] corner_out;
        logic                present;
    } t_out;

    typedef struct packed {
        logic                v;
        logic [CORNER_W-1:0] corner;
    } t_entry;

    typedef struct packed {
        logic              v;
        logic [SLOT_W-1:0] slot;
    } t_owner;

    typedef struct packed {
        logic                         is_read;
        logic                         bad;
        logic                         rok;
        logic [VIEW_W-1:0]            rframe;
        logic [SEL_W-1:0]             sel;
        t_entry [NUM_VIEWS-1:0]       pend;
    } t_cmd;

endpackage

### rtl/ftm_front.sv
// front end: config registers, view to frame mapping, pending track, command issue
module ftm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ftm_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [ftm_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ftm_pkg::t_in                i_in_data,
    input  logic                        i_busy,
    input  logic                        i_cmd_full,
    output logic                        o_cmd_push,
    output ftm_pkg::t_cmd               o_cmd,
    output logic                        o_clear
);

    logic signed [15:0]               r_first;
    logic [7:0]                       r_step;
    logic [ftm_pkg::VCOUNT_W-1:0]     r_vcount;
    ftm_pkg::t_entry [ftm_pkg::NUM_VIEWS-1:0] r_pend;
    logic                             r_bad;

    ftm_pkg::t_entry [ftm_pkg::NUM_VIEWS-1:0] n_pend;
    logic                             n_bad;
    logic signed [16:0]               diff;
    logic [7:0]                       step_e;
    logic [ftm_pkg::EFF_W-1:0]        eff;
    logic [ftm_pkg::NUM_VIEWS-1:0]    hit;
    logic [ftm_pkg::VIEW_W-1:0]       frame;
    logic [11:0]                      mult;
    logic                             pair_ok;
    logic                             accept;

    assign o_in_ready = !i_cmd_full && !i_busy && !i_cfg_we;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_clear = 1'b0;
        unique case (i_cfg_addr)
            ftm_pkg::CFG_VIEW_FIRST, ftm_pkg::CFG_VIEW_STEP,
            ftm_pkg::CFG_VIEW_COUNT: o_clear = i_cfg_we;
            default: o_clear = 1'b0;
        endcase
    end

    always_comb begin
        diff   = 17'($signed({i_in_data.view[15], i_in_data.view}))
                 - 17'($signed({r_first[15], r_first}));
        step_e = (r_step == 8'd0) ? 8'd1 : r_step;
        eff    = (ftm_pkg::EFF_W'(r_vcount) > ftm_pkg::EFF_W'(ftm_pkg::NUM_VIEWS))
                 ? ftm_pkg::EFF_W'(ftm_pkg::NUM_VIEWS) : ftm_pkg::EFF_W'(r_vcount);
        frame  = '0;
        mult   = '0;
        for (int k = 0; k < ftm_pkg::NUM_VIEWS; k++) begin
            mult   = 12'(step_e) * 12'(k);
            hit[k] = !diff[16] && (diff == 17'(mult))
                     && (ftm_pkg::EFF_W'(k) < eff);
            frame  = frame | (hit[k] ? ftm_pkg::VIEW_W'(k) : '0);
        end
        pair_ok = (|hit) && (17'(i_in_data.corner) < 17'(ftm_pkg::NUM_CORNERS));

        n_pend = r_pend;
        n_bad  = r_bad;
        if (pair_ok) begin
            n_pend[frame] = {1'b1, i_in_data.corner};
        end else begin
            n_bad = 1'b1;
        end

        o_cmd.is_read = i_in_data.mode;
        o_cmd.bad     = n_bad;
        o_cmd.pend    = n_pend;
        o_cmd.sel     = i_in_data.track_select;
        o_cmd.rok     = !i_in_data.view[15]
                        && (16'(i_in_data.view) < 16'(eff));
        o_cmd.rframe  = i_in_data.view[ftm_pkg::VIEW_W-1:0];
        o_cmd_push    = accept && (i_in_data.mode || i_in_data.last_pair);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_step   <= 8'd1;
            r_vcount <= ftm_pkg::VCOUNT_W'(8);
            r_pend   <= '0;
            r_bad    <= 1'b0;
        end else if (o_clear) begin
            case (i_cfg_addr)
                ftm_pkg::CFG_VIEW_FIRST: r_first  <= i_cfg_wdata;
                ftm_pkg::CFG_VIEW_STEP:  r_step   <= i_cfg_wdata[7:0];
                default:                 r_vcount <= i_cfg_wdata[ftm_pkg::VCOUNT_W-1:0];
            endcase
            r_pend <= '0;
            r_bad  <= 1'b0;
        end else if (accept && !i_in_data.mode) begin
            if (i_in_data.last_pair) begin
                r_pend <= '0;
                r_bad  <= 1'b0;
            end else begin
                r_pend <= n_pend;
                r_bad  <= n_bad;
            end
        end
    end

endmodule

### rtl/ftm_queue.sv
// two entry command queue between front and back
module ftm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ftm_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output ftm_pkg::t_cmd o_data,
    input  logic          i_pop
);

    ftm_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_n;

    assign o_full  = (r_n == 2'd2);
    assign o_valid = (r_n != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_n <= r_n + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### rtl/ftm_back.sv
// back end: track store, owner map, merge and removal sequencer, result register
module ftm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    output logic          o_busy,
    input  logic          i_cmd_valid,
    input  ftm_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ftm_pkg::t_out o_out_data
);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_LOOK   = 13'b0000000000100,
        S_DECIDE = 13'b0000000001000,
        S_APPEND = 13'b0000000010000,
        S_MERGE  = 13'b0000000100000,
        S_WMERGE = 13'b0000001000000,
        S_REMOVE = 13'b0000010000000,
        S_UNMAP  = 13'b0000100000000,
        S_MVCHK  = 13'b0001000000000,
        S_MOVE   = 13'b0010000000000,
        S_STEPK  = 13'b0100000000000,
        S_READ   = 13'b1000000000000
    } t_state;

    localparam int NV = ftm_pkg::NUM_VIEWS;
    localparam int VW = ftm_pkg::VIEW_W;

    ftm_pkg::t_owner r_map [ftm_pkg::MAP_DEPTH];
    ftm_pkg::t_entry r_ts  [ftm_pkg::TS_DEPTH];
    ftm_pkg::t_owner r_map_q;
    ftm_pkg::t_entry r_ts_q;

    t_state                         r_state;
    logic                           r_rwait;
    logic                           r_outp;
    logic [ftm_pkg::CNT_W-1:0]      r_cnt;
    logic [ftm_pkg::MAP_AW:0]       r_clr;
    ftm_pkg::t_entry [NV-1:0]       r_merged;
    logic [ftm_pkg::SLOT_W-1:0]     r_sh [NV];
    logic [ftm_pkg::CNT_W-1:0]      r_shn;
    logic [VW-1:0]                  r_k;
    logic                           r_ok;
    logic [ftm_pkg::COUNT_W-1:0]    r_count;
    logic [ftm_pkg::SEL_W-1:0]      r_sel;
    logic [VW-1:0]                  r_rframe;
    logic                           r_rok;
    logic [2:0]                     r_status;
    logic [ftm_pkg::SEL_W-1:0]      r_id;
    logic [ftm_pkg::CORNER_W-1:0]   r_cout;
    logic                           r_present;
    logic                           r_oval;
    ftm_pkg::t_out                  r_out;

    logic                           map_we;
    logic [ftm_pkg::MAP_AW-1:0]     map_waddr;
    ftm_pkg::t_owner                map_wdata;
    logic [ftm_pkg::MAP_AW-1:0]     map_raddr;
    logic                           ts_we;
    logic [ftm_pkg::TS_AW-1:0]      ts_waddr;
    ftm_pkg::t_entry                ts_wdata;
    logic [ftm_pkg::TS_AW-1:0]      ts_raddr;

    logic [VW-1:0]                  fcur;
    logic [VW-1:0]                  fprev;
    logic                           sweep_end;
    logic [ftm_pkg::SLOT_W-1:0]     sk;
    logic [ftm_pkg::SLOT_W-1:0]     last_slot;
    logic [ftm_pkg::SLOT_W-1:0]     n_sh [NV];
    logic [ftm_pkg::CNT_W-1:0]      n_shn;
    logic [ftm_pkg::CNT_W-1:0]      pos;
    logic                           dup;
    ftm_pkg::t_entry [NV-1:0]       n_merged;
    logic                           n_ok;
    logic                           out_free;

    assign fcur      = r_cnt[VW-1:0];
    assign fprev     = VW'(r_cnt - 1'b1);
    assign sweep_end = (r_cnt == ftm_pkg::CNT_W'(NV));
    assign sk        = r_sh[r_k];
    assign last_slot = ftm_pkg::SLOT_W'(r_count - 1'b1);
    assign o_busy    = (r_state == S_CLEAR);
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && !r_rwait && !r_outp;
    assign out_free  = !r_oval || i_out_ready;
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    // owner insertion into the sorted sharer list
    always_comb begin
        dup = 1'b0;
        pos = '0;
        for (int i = 0; i < NV; i++) begin
            if (ftm_pkg::CNT_W'(i) < r_shn) begin
                if (r_sh[i] == r_map_q.slot) begin
                    dup = 1'b1;
                end
                if (r_sh[i] < r_map_q.slot) begin
                    pos = pos + 1'b1;
                end
            end
        end
        for (int i = 0; i < NV; i++) begin
            if (ftm_pkg::CNT_W'(i) < pos) begin
                n_sh[i] = r_sh[i];
            end else if (ftm_pkg::CNT_W'(i) == pos) begin
                n_sh[i] = r_map_q.slot;
            end else begin
                n_sh[i] = r_sh[(i > 0) ? i - 1 : 0];
            end
        end
        n_shn = r_shn + 1'b1;
    end

    always_comb begin
        n_merged = r_merged;
        n_ok     = r_ok;
        if (r_merged[fprev].v && r_ts_q.v && (r_merged[fprev] != r_ts_q)) begin
            n_ok = 1'b0;
        end else if (!r_merged[fprev].v) begin
            n_merged[fprev] = r_ts_q;
        end
    end

    always_comb begin
        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_raddr = {fcur, r_merged[fcur].corner[ftm_pkg::CORNER_AW-1:0]};
        ts_we     = 1'b0;
        ts_waddr  = '0;
        ts_wdata  = r_ts_q;
        ts_raddr  = {sk, fcur};
        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr[ftm_pkg::MAP_AW-1:0];
            end
            S_APPEND: begin
                ts_we     = 1'b1;
                ts_waddr  = {r_count[ftm_pkg::SLOT_W-1:0], fcur};
                ts_wdata  = r_merged[fcur];
                map_we    = r_merged[fcur].v;
                map_waddr = {fcur, r_merged[fcur].corner[ftm_pkg::CORNER_AW-1:0]};
                map_wdata = {1'b1, r_count[ftm_pkg::SLOT_W-1:0]};
            end
            S_WMERGE: begin
                ts_we     = 1'b1;
                ts_waddr  = {r_sh[0], fcur};
                ts_wdata  = r_merged[fcur];
                map_we    = r_merged[fcur].v;
                map_waddr = {fcur, r_merged[fcur].corner[ftm_pkg::CORNER_AW-1:0]};
                map_wdata = {1'b1, r_sh[0]};
            end
            S_UNMAP: begin
                map_we    = (r_cnt != '0) && r_ts_q.v;
                map_waddr = {fprev, r_ts_q.corner[ftm_pkg::CORNER_AW-1:0]};
            end
            S_MOVE: begin
                ts_raddr  = {last_slot, fcur};
                ts_we     = (r_cnt != '0);
                ts_waddr  = {sk, fprev};
                map_we    = (r_cnt != '0) && r_ts_q.v;
                map_waddr = {fprev, r_ts_q.corner[ftm_pkg::CORNER_AW-1:0]};
                map_wdata = {1'b1, sk};
            end
            S_READ: begin
                ts_raddr  = {r_sel[ftm_pkg::SLOT_W-1:0], r_rframe};
            end
            default: begin
                map_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        r_map_q <= r_map[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ts_we) begin
            r_ts[ts_waddr] <= ts_wdata;
        end
        r_ts_q <= r_ts[ts_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_oval  <= 1'b0;
            r_rwait <= 1'b0;
            r_outp  <= 1'b0;
            r_cnt   <= '0;
            r_shn   <= '0;
            r_k     <= '0;
            r_ok    <= 1'b1;
        end else if (i_clear) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            if (r_rwait) begin
                r_rwait   <= 1'b0;
                r_outp    <= 1'b1;
                r_present <= r_rok && r_ts_q.v;
                r_cout    <= (r_rok && r_ts_q.v) ? r_ts_q.corner : '0;
            end
            if (r_outp && out_free) begin
                r_outp <= 1'b0;
                r_oval <= 1'b1;
                r_out  <= '{status: r_status, track_id: r_id, track_total: r_count,
                            corner_out: r_cout, present: r_present};
            end else if (r_oval && i_out_ready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (ftm_pkg::MAP_AW + 1)'(ftm_pkg::MAP_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_merged  <= i_cmd.pend;
                        r_sel     <= i_cmd.sel;
                        r_rframe  <= i_cmd.rframe;
                        r_rok     <= i_cmd.rok;
                        r_cnt     <= '0;
                        r_shn     <= '0;
                        r_ok      <= 1'b1;
                        r_cout    <= '0;
                        r_present <= 1'b0;
                        r_id      <= '0;
                        if (i_cmd.is_read) begin
                            r_state <= S_READ;
                        end else if (i_cmd.bad) begin
                            r_status <= ftm_pkg::ST_BAD_VIEW;
                            r_outp   <= 1'b1;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if ((r_cnt != '0) && r_merged[fprev].v && r_map_q.v
                        && (ftm_pkg::COUNT_W'(r_map_q.slot) < r_count) && !dup) begin
                        r_sh  <= n_sh;
                        r_shn <= n_shn;
                    end
                    if (sweep_end) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_cnt <= '0;
                    r_k   <= '0;
                    if (r_shn == '0) begin
                        if (r_count >= ftm_pkg::COUNT_W'(ftm_pkg::MAX_TRACKS)) begin
                            r_status <= ftm_pkg::ST_FULL;
                            r_outp   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_APPEND;
                        end
                    end else begin
                        r_state <= S_MERGE;
                    end
                end
                S_APPEND: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ftm_pkg::CNT_W'(NV - 1)) begin
                        r_status <= ftm_pkg::ST_NEW;
                        r_id     <= ftm_pkg::SEL_W'(r_count);
                        r_count  <= r_count + 1'b1;
                        r_outp   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_MERGE: begin
                    if (r_cnt != '0) begin
                        r_merged <= n_merged;
                        r_ok     <= n_ok;
                    end
                    if (sweep_end) begin
                        r_cnt <= '0;
                        if (!n_ok) begin
                            r_status <= ftm_pkg::ST_CONFLICT;
                            r_id     <= '0;
                            r_k      <= VW'(r_shn - 1'b1);
                            r_state  <= S_REMOVE;
                        end else if (ftm_pkg::CNT_W'(r_k) == r_shn - 1'b1) begin
                            r_state <= S_WMERGE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WMERGE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ftm_pkg::CNT_W'(NV - 1)) begin
                        r_status <= ftm_pkg::ST_MERGED;
                        r_id     <= ftm_pkg::SEL_W'(r_sh[0]);
                        r_k      <= VW'(r_shn - 1'b1);
                        if (r_shn == ftm_pkg::CNT_W'(1)) begin
                            r_outp  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_REMOVE;
                        end
                    end
                end
                S_REMOVE: begin
                    r_cnt   <= '0;
                    r_state <= r_ok ? S_MVCHK : S_UNMAP;
                end
                S_UNMAP: begin
                    if (sweep_end) begin
                        r_cnt   <= '0;
                        r_state <= S_MVCHK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MVCHK: begin
                    if (r_count == '0) begin
                        r_state <= S_STEPK;
                    end else if (ftm_pkg::COUNT_W'(sk) + 1'b1 != r_count) begin
                        r_state <= S_MOVE;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_STEPK;
                    end
                end
                S_MOVE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (sweep_end) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_STEPK;
                    end
                end
                S_STEPK: begin
                    if ((r_ok && r_k == VW'(1)) || (!r_ok && r_k == '0)) begin
                        r_outp  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_REMOVE;
                    end
                end
                S_READ: begin
                    r_rok    <= r_rok && (ftm_pkg::COUNT_W'(r_sel) < r_count);
                    r_status <= ftm_pkg::ST_READ;
                    r_id     <= r_sel;
                    r_rwait  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ftm_pkg::COUNT_W'(ftm_pkg::MAX_TRACKS))
        else $error("track count above table size");

    a_share_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shn <= ftm_pkg::CNT_W'(NV))
        else $error("sharer list overflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1
            || r_count == $past(r_count) - 1'b1 || r_count == '0))
        else $error("track count jumped");

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cmd_pop)
        else $error("command taken during map clear");

endmodule

### rtl/feature_track_merge_table_top.sv
// top level of the feature track merge table
//
// channel   dir  handshake                  payload
// cfg       in   i_cfg_we                   i_cfg_addr, i_cfg_wdata
// in        in   i_in_valid / o_in_ready    i_in_data  (t_in)
// out       out  o_out_valid / i_out_ready  o_out_data (t_out)
//
// a pair that does not finish a track only updates the pending track; a read result is registered
// a finished track is issued through the queue, then a map lookup and a decide step, then an append,
// or a merge per sharer, a write back and a removal per removed sharer
// after reset and after a config write to one of the three config registers the owner map is cleared
// a waiting result does not hold up the back end until the next result is ready
module feature_track_merge_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ftm_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [ftm_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ftm_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ftm_pkg::t_out               o_out_data
);

    logic          busy;
    logic          clear;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_valid;
    logic          cmd_pop;
    ftm_pkg::t_cmd cmd_in;
    ftm_pkg::t_cmd cmd_out;

    ftm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_busy      (busy),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .o_clear     (clear)
    );

    ftm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_data  (cmd_out),
        .i_pop   (cmd_pop)
    );

    ftm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .o_busy      (busy),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
